/* hw/rtl/dwc_pkg.sv */
// shared types and constants of the depthwise 3x3 convolution block
`default_nettype none

package dwc_pkg;

    // fixed field widths
    localparam int DATA_W         = 16;
    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_FRAC_BITS = 14;
    localparam int MAX_SIZE       = 32;
    localparam int POS_W          = 6;
    localparam int CMD_W          = 2;
    localparam int TAP_W          = 4;
    localparam int COORD_W        = 5;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 6;
    localparam int NTAPS          = 9;
    localparam int NSLOTS         = 4;
    localparam int PROD_W         = 2 * DATA_W;
    localparam int ACC_W          = PROD_W + 4;

    // item commands
    localparam logic [CMD_W-1:0] CMD_TAP   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BIAS  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_TWO = 2'd1;

    localparam logic [TAP_W-1:0]  LAST_TAP  = 4'd8;
    localparam logic [POS_W-1:0]  MIN_FRAME = 6'd4;
    localparam logic [POS_W-1:0]  RST_FRAME = 6'd16;

    // one pixel's worth of work for the back end
    typedef struct packed {
        logic [NTAPS-1:0][DATA_W-1:0] window;
        logic [NTAPS-1:0][DATA_W-1:0] taps;
        logic [DATA_W-1:0]            bias;
        logic [POS_W-1:0]             row;
        logic [POS_W-1:0]             col;
        logic [POS_W-1:0]             size;
        logic                         stride;
        logic [NSLOTS-1:0]            mask;
    } job_t;

endpackage

`default_nettype wire

/* hw/rtl/dwc_front.sv */
// front end: item intake, line store, window, tap and bias registers, job build
`default_nettype none

module dwc_front
    import dwc_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_write,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [CMD_W-1:0]        command,
    input  wire logic [TAP_W-1:0]        tap_index,
    input  wire logic [DATA_W-1:0]       coefficient,
    input  wire logic [DATA_W-1:0]       bias_value,
    input  wire logic [DATA_W-1:0]       pixel,
    output logic                         job_valid,
    input  wire logic                    job_ready,
    output job_t                         job
);

    localparam int ADDR_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

    logic [POS_W-1:0]  frame_size_reg;
    logic              stride_reg;
    logic [POS_W-1:0]  row_reg, row_next;
    logic [POS_W-1:0]  col_reg, col_next;

    logic              s1_valid_reg;
    logic [CMD_W-1:0]  s1_cmd_reg;
    logic [TAP_W-1:0]  s1_tap_reg;
    logic [DATA_W-1:0] s1_coef_reg;
    logic [DATA_W-1:0] s1_bias_reg;
    logic [DATA_W-1:0] s1_pixel_reg;
    logic [POS_W-1:0]  s1_row_reg;
    logic [POS_W-1:0]  s1_col_reg;

    logic [2*DATA_W-1:0] line_mem [MAX_SIZE];
    logic [2*DATA_W-1:0] rd_data_reg;

    logic [NTAPS-1:0][DATA_W-1:0] window_reg, window_next;
    logic [NTAPS-1:0][DATA_W-1:0] taps_reg;
    logic [DATA_W-1:0]            bias_reg;

    logic              in_acc;
    logic              s1_push;
    logic              s1_done;
    logic              s1_pix;
    logic [POS_W-1:0]  cfg_size;
    logic [NSLOTS-1:0] mask;
    logic              rv0, rv1, cv0, cv1;

    // intake handshake
    assign s1_pix   = s1_valid_reg && (s1_cmd_reg == CMD_PIXEL);
    assign s1_push  = s1_pix && (mask != '0);
    assign in_ready = !s1_valid_reg || !s1_push || job_ready;
    assign in_acc   = in_valid && in_ready;
    assign s1_done  = s1_valid_reg && (!s1_push || job_ready);

    // frame size clamp
    always_comb
    begin
        cfg_size = cfg_data;
        if (cfg_data < MIN_FRAME)
        begin
            cfg_size = MIN_FRAME;
        end
        else if (int'(cfg_data) > MAX_SIZE)
        begin
            cfg_size = POS_W'(MAX_SIZE);
        end
    end

    // raster position of the next pixel
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (col_reg == frame_size_reg - 1'b1)
        begin
            col_next = '0;
            row_next = (row_reg == frame_size_reg - 1'b1) ? '0 : row_reg + 1'b1;
        end
        else
        begin
            col_next = col_reg + 1'b1;
        end
    end

    // configuration and position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_size_reg <= RST_FRAME;
            stride_reg     <= 1'b0;
            row_reg        <= '0;
            col_reg        <= '0;
        end
        else if (cfg_write && (cfg_index == REG_FRAME_SIZE || cfg_index == REG_STRIDE_TWO))
        begin
            if (cfg_index == REG_FRAME_SIZE)
            begin
                frame_size_reg <= cfg_size;
            end
            else
            begin
                stride_reg <= cfg_data[0];
            end
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (in_acc && command == CMD_PIXEL)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // second stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_done)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // second stage payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_cmd_reg   <= command;
            s1_tap_reg   <= tap_index;
            s1_coef_reg  <= coefficient;
            s1_bias_reg  <= bias_value;
            s1_pixel_reg <= pixel;
            s1_row_reg   <= row_reg;
            s1_col_reg   <= col_reg;
        end
    end

    // line store: one entry per column holds the two previous rows
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            rd_data_reg <= line_mem[ADDR_W'(col_reg)];
        end
        if (s1_done && s1_pix)
        begin
            line_mem[ADDR_W'(s1_col_reg)] <= {rd_data_reg[DATA_W-1:0], s1_pixel_reg};
        end
    end

    // window shift
    always_comb
    begin
        window_next = window_reg;
        for (int i = 0; i < 3; i++)
        begin
            window_next[i*3]     = window_reg[i*3+1];
            window_next[i*3+1]   = window_reg[i*3+2];
        end
        window_next[2] = rd_data_reg[2*DATA_W-1:DATA_W];
        window_next[5] = rd_data_reg[DATA_W-1:0];
        window_next[8] = s1_pixel_reg;
    end

    // window, taps and bias
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            taps_reg   <= '0;
            bias_reg   <= '0;
        end
        else if (s1_done)
        begin
            if (s1_pix)
            begin
                window_reg <= window_next;
            end
            else if (s1_cmd_reg == CMD_TAP && s1_tap_reg <= LAST_TAP)
            begin
                taps_reg[s1_tap_reg] <= s1_coef_reg;
            end
            else if (s1_cmd_reg == CMD_BIAS)
            begin
                bias_reg <= s1_bias_reg;
            end
        end
    end

    // which of the up to four outputs are due
    always_comb
    begin
        rv0 = (s1_row_reg != '0);
        rv1 = (s1_row_reg == frame_size_reg - 1'b1);
        cv0 = (s1_col_reg != '0);
        cv1 = (s1_col_reg == frame_size_reg - 1'b1);
        mask[0] = rv0 && cv0 && (!stride_reg || (s1_row_reg[0] && s1_col_reg[0]));
        mask[1] = rv0 && cv1 && (!stride_reg || (s1_row_reg[0] && !s1_col_reg[0]));
        mask[2] = rv1 && cv0 && (!stride_reg || (!s1_row_reg[0] && s1_col_reg[0]));
        mask[3] = rv1 && cv1 && (!stride_reg || (!s1_row_reg[0] && !s1_col_reg[0]));
    end

    // job to the queue
    assign job_valid  = s1_push;
    assign job.window = window_next;
    assign job.taps   = taps_reg;
    assign job.bias   = bias_reg;
    assign job.row    = s1_row_reg;
    assign job.col    = s1_col_reg;
    assign job.size   = frame_size_reg;
    assign job.stride = stride_reg;
    assign job.mask   = mask;

endmodule

`default_nettype wire

/* hw/rtl/dwc_queue.sv */
// two-entry job queue between front and back end
`default_nettype none

module dwc_queue
    import dwc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire job_t push_job,
    output logic      pop_valid,
    input  wire logic pop,
    output job_t      pop_job
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_job    = entry_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/dwc_back.sv */
// back end: output sequencer, nine-tap multiply, sum, round and saturate
`default_nettype none

module dwc_back
    import dwc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 job_valid,
    output logic                      job_pop,
    input  wire job_t                 job,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [DATA_W-1:0]         value,
    output logic [COORD_W-1:0]        out_row,
    output logic [COORD_W-1:0]        out_col,
    output logic                      saturated,
    output logic                      last
);

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] ROUND  = ACC_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));

    job_t              cur_reg;
    logic              cur_valid_reg;
    logic [NSLOTS-1:0] rem_reg;

    logic                                a_valid_reg;
    logic signed [PROD_W-1:0]            a_prod_reg [NTAPS];
    logic [DATA_W-1:0]                   a_bias_reg;
    logic [COORD_W-1:0]                  a_row_reg, a_col_reg;
    logic                                a_last_reg;

    logic                                b_valid_reg;
    logic signed [ACC_W-1:0]             b_acc_reg;
    logic [COORD_W-1:0]                  b_row_reg, b_col_reg;
    logic                                b_last_reg;

    logic                                out_valid_reg;
    logic [DATA_W-1:0]                   value_reg;
    logic [COORD_W-1:0]                  row_out_reg, col_out_reg;
    logic                                sat_reg, last_reg;

    logic                                en;
    logic                                issue;
    logic                                dr, dc;
    logic [NSLOTS-1:0]                   pick;
    logic [NSLOTS-1:0]                   rem_after;
    logic                                is_last;
    logic signed [PROD_W-1:0]            prod [NTAPS];
    logic [POS_W-1:0]                    oh, ow;
    logic signed [ACC_W-1:0]             acc;
    logic signed [ACC_W-1:0]             shifted;

    // whole pipeline moves unless the output register is stuck
    assign en    = !out_valid_reg || out_ready;
    assign issue = en && cur_valid_reg;

    // lowest pending output of the current job
    always_comb
    begin
        pick = '0;
        dr   = 1'b0;
        dc   = 1'b0;
        if (rem_reg[0])
        begin
            pick[0] = 1'b1;
        end
        else if (rem_reg[1])
        begin
            pick[1] = 1'b1;
            dc      = 1'b1;
        end
        else if (rem_reg[2])
        begin
            pick[2] = 1'b1;
            dr      = 1'b1;
        end
        else
        begin
            pick[3] = 1'b1;
            dr      = 1'b1;
            dc      = 1'b1;
        end
        rem_after = rem_reg & ~pick;
        is_last   = (rem_after == '0);
    end

    assign job_pop = en && job_valid && (!cur_valid_reg || is_last);

    // current job
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            rem_reg       <= '0;
        end
        else if (job_pop)
        begin
            cur_valid_reg <= 1'b1;
            rem_reg       <= job.mask;
        end
        else if (issue)
        begin
            rem_reg <= rem_after;
            if (is_last)
            begin
                cur_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            cur_reg <= job;
        end
    end

    // masked tap products, zero padding outside the plane
    always_comb
    begin
        int wi, wj, ir, ic, wis, wjs;
        for (int m = 0; m < 3; m++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                wi  = m + int'(dr);
                wj  = k + int'(dc);
                ir  = int'(cur_reg.row) - 2 + wi;
                ic  = int'(cur_reg.col) - 2 + wj;
                wis = (wi > 2) ? 2 : wi;
                wjs = (wj > 2) ? 2 : wj;
                if (wi <= 2 && wj <= 2 && ir >= 0 && ic >= 0
                    && ir < int'(cur_reg.size) && ic < int'(cur_reg.size))
                begin
                    prod[m*3+k] = $signed(cur_reg.taps[m*3+k])
                                * $signed(cur_reg.window[wis*3+wjs]);
                end
                else
                begin
                    prod[m*3+k] = '0;
                end
            end
        end
    end

    // output coordinates
    always_comb
    begin
        oh = cur_reg.row - POS_W'(!dr);
        ow = cur_reg.col - POS_W'(!dc);
        if (cur_reg.stride)
        begin
            oh = oh >> 1;
            ow = ow >> 1;
        end
    end

    // stage a: products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_prod_reg <= prod;
            a_bias_reg <= cur_reg.bias;
            a_row_reg  <= oh[COORD_W-1:0];
            a_col_reg  <= ow[COORD_W-1:0];
            a_last_reg <= is_last;
        end
    end

    // sum with bias and rounding constant
    always_comb
    begin
        acc = ACC_W'($signed(a_bias_reg)) <<< COEF_FRAC_BITS;
        acc = acc + ROUND;
        for (int t = 0; t < NTAPS; t++)
        begin
            acc = acc + ACC_W'(a_prod_reg[t]);
        end
    end

    // stage b: sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_acc_reg  <= acc;
            b_row_reg  <= a_row_reg;
            b_col_reg  <= a_col_reg;
            b_last_reg <= a_last_reg;
        end
    end

    // output register: round down and saturate
    assign shifted = b_acc_reg >>> COEF_FRAC_BITS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (shifted > SAT_HI)
            begin
                value_reg <= SAT_HI[DATA_W-1:0];
                sat_reg   <= 1'b1;
            end
            else if (shifted < SAT_LO)
            begin
                value_reg <= SAT_LO[DATA_W-1:0];
                sat_reg   <= 1'b1;
            end
            else
            begin
                value_reg <= shifted[DATA_W-1:0];
                sat_reg   <= 1'b0;
            end
            row_out_reg <= b_row_reg;
            col_out_reg <= b_col_reg;
            last_reg    <= b_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign out_row   = row_out_reg;
    assign out_col   = col_out_reg;
    assign saturated = sat_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

/* hw/rtl/depthwise_conv3x3_stream_top.sv */
// top level of the streaming 3x3 depthwise convolution block
`default_nettype none

// Takes one item per clock while in_ready is high: tap loads, bias loads and raster
// pixels of a square plane (4 to MAX_SIZE pixels wide, zero padded, stride one or two).
// The front end reads the two-row line store, shifts the 3x3 window and hands each pixel
// that completes outputs to a two-entry job queue; the back end issues one output per
// clock while out_ready does not stall it, through a multiply, sum and round/saturate
// pipeline. A pixel at the right or bottom edge can cause up to four outputs and then
// holds the back end until they are issued; the queue lets intake continue meanwhile.
// Sustained input rate is one item per clock as long as the outputs due average no more
// than one per clock and out_ready stays high. The line store needs no clearing: any
// entry read in a plane before it was written in that plane lands in padding, which masks it.
module depthwise_conv3x3_stream_top
    import dwc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [CMD_W-1:0]      command,
    input  wire logic [TAP_W-1:0]      tap_index,
    input  wire logic [DATA_W-1:0]     coefficient,
    input  wire logic [DATA_W-1:0]     bias_value,
    input  wire logic [DATA_W-1:0]     pixel,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [DATA_W-1:0]          value,
    output logic [COORD_W-1:0]         out_row,
    output logic [COORD_W-1:0]         out_col,
    output logic                       saturated,
    output logic                       last
);

    logic job_valid;
    logic job_ready;
    job_t job_in;
    logic q_valid;
    logic q_pop;
    job_t q_job;

    assign cfg_ready = 1'b1;

    dwc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .tap_index   (tap_index),
        .coefficient (coefficient),
        .bias_value  (bias_value),
        .pixel       (pixel),
        .job_valid   (job_valid),
        .job_ready   (job_ready),
        .job         (job_in)
    );

    dwc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (job_valid),
        .push_ready (job_ready),
        .push_job   (job_in),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_job    (q_job)
    );

    dwc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job_pop   (q_pop),
        .job       (q_job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .out_row   (out_row),
        .out_col   (out_col),
        .saturated (saturated),
        .last      (last)
    );

    // a job refused by a full queue is offered again
    assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid && !job_ready) |=> job_valid)
        else $error("job dropped while queue full");

    // intake stalls only behind a refused job
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (job_valid && !job_ready))
        else $error("intake stalled without cause");

    // back end never takes from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

/* verif/depthwise_conv3x3_stream_top_test.sv */
// self-checking testbench of the streaming 3x3 depthwise convolution block
`default_nettype none

module depthwise_conv3x3_stream_top_test
    import dwc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PLANE_MAX  = 32;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_WAIT = 24;
    localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    // one output sample as it leaves the block
    typedef struct packed {
        logic [DATA_W-1:0]  value;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               sat;
        logic               last;
    } conv_out_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [CMD_W-1:0]      command = '0;
    logic [TAP_W-1:0]      tap_index = '0;
    logic [DATA_W-1:0]     coefficient = '0;
    logic [DATA_W-1:0]     bias_value = '0;
    logic [DATA_W-1:0]     pixel = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [DATA_W-1:0]     value;
    logic [COORD_W-1:0]    out_row;
    logic [COORD_W-1:0]    out_col;
    logic                  saturated;
    logic                  last;

    // predictor state
    int                      plane_n;
    bit                      stride2;
    logic signed [DATA_W-1:0] line_mem [2*PLANE_MAX];
    logic signed [DATA_W-1:0] win [NTAPS];
    logic signed [DATA_W-1:0] tap_w [NTAPS];
    logic signed [DATA_W-1:0] plane_bias;
    int                      cur_row;
    int                      cur_col;

    conv_out_t expected_q [$];
    int  mismatches = 0;
    int  items_sent = 0;
    int  outputs_seen = 0;
    int  sat_seen = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;
    int  out_stall = 0;

    always #2 clk = ~clk;

    depthwise_conv3x3_stream_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .tap_index   (tap_index),
        .coefficient (coefficient),
        .bias_value  (bias_value),
        .pixel       (pixel),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .value       (value),
        .out_row     (out_row),
        .out_col     (out_col),
        .saturated   (saturated),
        .last        (last)
    );

    // random gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // sample value biased toward the extremes
    function automatic logic [DATA_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // clear predictor state as after reset
    function automatic void model_reset();
        plane_n = 16;
        stride2 = 1'b0;
        foreach (line_mem[i]) line_mem[i] = '0;
        foreach (win[i]) win[i] = '0;
        foreach (tap_w[i]) tap_w[i] = '0;
        plane_bias = '0;
        cur_row = 0;
        cur_col = 0;
    endfunction

    // register write: clamp the frame size, restart the plane on a size or stride write
    function automatic void model_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        if (idx == REG_FRAME_SIZE) begin
            plane_n = (d < 4) ? 4 : (d > PLANE_MAX) ? PLANE_MAX : int'(d);
        end
        else if (idx == REG_STRIDE_TWO) begin
            stride2 = d[0];
        end
        else begin
            return;
        end
        cur_row = 0;
        cur_col = 0;
    endfunction

    // one filtered output centred on (oh, ow) with the newest pixel at (r, c)
    function automatic conv_out_t filter_at(int oh, int ow, int r, int c);
        conv_out_t o;
        longint acc;
        longint v;
        int ir;
        int ic;
        int wi;
        int wj;
        acc = longint'(plane_bias) * 16384;
        for (int m = 0; m < 3; m++) begin
            for (int k = 0; k < 3; k++) begin
                ir = oh - 1 + m;
                ic = ow - 1 + k;
                wi = ir - (r - 2);
                wj = ic - (c - 2);
                if (ir >= 0 && ic >= 0 && ir < plane_n && ic < plane_n &&
                    wi >= 0 && wi <= 2 && wj >= 0 && wj <= 2)
                    acc += longint'(tap_w[m*3+k]) * longint'(win[wi*3+wj]);
            end
        end
        acc += 8192;
        v = acc >>> COEF_FRAC_BITS;
        o.sat = 1'b0;
        if (v > 32767) begin
            v = 32767;
            o.sat = 1'b1;
        end
        if (v < -32768) begin
            v = -32768;
            o.sat = 1'b1;
        end
        if (stride2) begin
            oh = oh >> 1;
            ow = ow >> 1;
        end
        o.value = DATA_W'(v);
        o.row = COORD_W'(oh);
        o.col = COORD_W'(ow);
        o.last = 1'b0;
        return o;
    endfunction

    // apply one accepted item and queue the outputs it completes
    function automatic void model_item(logic [CMD_W-1:0] cmd, logic [TAP_W-1:0] tap,
                                       logic [DATA_W-1:0] coef, logic [DATA_W-1:0] bv,
                                       logic [DATA_W-1:0] pix);
        int r;
        int c;
        int rows [2];
        int cols [2];
        int nr;
        int nc;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        conv_out_t outs [$];
        if (cmd == CMD_TAP) begin
            if (tap <= LAST_TAP) tap_w[tap] = coef;
            return;
        end
        if (cmd == CMD_BIAS) begin
            plane_bias = bv;
            return;
        end
        if (cmd != CMD_PIXEL) return;
        if (cur_row >= plane_n) cur_row = 0;
        if (cur_col >= plane_n) cur_col = 0;
        r = cur_row;
        c = cur_col;
        // line store and window shift
        a = line_mem[c];
        b = line_mem[PLANE_MAX+c];
        line_mem[c] = b;
        line_mem[PLANE_MAX+c] = pix;
        for (int i = 0; i < 3; i++) begin
            win[i*3]   = win[i*3+1];
            win[i*3+1] = win[i*3+2];
        end
        win[2] = a;
        win[5] = b;
        win[8] = pix;
        // outputs whose last needed pixel this is
        nr = 0;
        nc = 0;
        if (r >= 1) begin
            rows[nr] = r - 1;
            nr++;
        end
        if (r == plane_n - 1) begin
            rows[nr] = r;
            nr++;
        end
        if (c >= 1) begin
            cols[nc] = c - 1;
            nc++;
        end
        if (c == plane_n - 1) begin
            cols[nc] = c;
            nc++;
        end
        for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nc; j++) begin
                if (!(stride2 && ((rows[i] | cols[j]) & 1) != 0))
                    outs.push_back(filter_at(rows[i], cols[j], r, c));
            end
        end
        if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
        foreach (outs[i]) expected_q.push_back(outs[i]);
        c++;
        if (c >= plane_n) begin
            c = 0;
            r++;
            if (r >= plane_n) r = 0;
        end
        cur_row = r;
        cur_col = c;
    endfunction

    // send one item and predict its outputs on acceptance
    task automatic send_item(logic [CMD_W-1:0] cmd, logic [TAP_W-1:0] tap,
                             logic [DATA_W-1:0] coef, logic [DATA_W-1:0] bv,
                             logic [DATA_W-1:0] pix);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
        in_valid = 1'b1;
        command = cmd;
        tap_index = tap;
        coefficient = coef;
        bias_value = bv;
        pixel = pix;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        model_item(cmd, tap, coef, bv, pix);
        items_sent++;
    endtask

    task automatic send_pixel(logic [DATA_W-1:0] pix);
        send_item(CMD_PIXEL, TAP_W'($urandom), DATA_W'($urandom), DATA_W'($urandom), pix);
    endtask

    // wait until the block is idle
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    // register write while the block is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        drain();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        model_config(idx, d);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // load all taps and the bias
    task automatic load_kernel(bit extreme);
        for (int t = 0; t < NTAPS; t++)
            send_item(CMD_TAP, TAP_W'(t), extreme ? 16'h7fff : pick_sample(), '0, '0);
        send_item(CMD_BIAS, '0, '0, extreme ? 16'h7fff : pick_sample(), '0);
    endtask

    // directed: reset defaults, extremes, ignored items, saturation, tiny frame
    task automatic test_directed();
        calm = 1'b1;
        send_pixel(16'h7fff);
        send_pixel(16'h8000);
        write_reg(REG_FRAME_SIZE, 6'd0);
        load_kernel(1'b1);
        send_item(CMD_TAP, 4'hf, 16'h8000, '0, '0);
        send_item(CMD_TAP, 4'h9, 16'h1234, '0, '0);
        send_item(CMD_UNUSED, 4'h3, 16'hffff, 16'hffff, 16'hffff);
        for (int i = 0; i < 16; i++) send_pixel((i % 3 == 0) ? 16'h8000 : 16'h7fff);
        calm = 1'b0;
    endtask

    // one plane: settings, kernel, pixels with some noise mixed in
    task automatic run_plane(logic [CFG_DATA_W-1:0] size_cfg, bit stride, int extra,
                             bit partial);
        int n;
        int count;
        write_reg(REG_FRAME_SIZE, size_cfg);
        write_reg(REG_STRIDE_TWO, {5'($urandom), stride});
        load_kernel(1'b0);
        n = plane_n;
        count = partial ? n + n / 2 + 5 : n * n + extra;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 39))
                0: send_item(CMD_UNUSED, TAP_W'($urandom), pick_sample(), pick_sample(),
                             pick_sample());
                1: send_item(CMD_TAP, TAP_W'($urandom_range(9, 15)), pick_sample(), '0, '0);
                2: send_item(CMD_TAP, TAP_W'($urandom_range(0, 8)), pick_sample(), '0, '0);
                default: ;
            endcase
            send_pixel(pick_sample());
        end
    endtask

    // random planes over sizes and strides, extremes included
    task automatic test_random_planes();
        write_reg(REG_SPARE, 6'h3f);
        run_plane(6'd63, 1'b0, 0, 1'b1);
        run_plane(6'd32, 1'b1, 0, 1'b1);
        run_plane(6'd4, 1'b1, 6, 1'b0);
        run_plane(6'd5, 1'b0, 0, 1'b0);
        calm = 1'b1;
        run_plane(6'd6, 1'b1, 3, 1'b0);
        calm = 1'b0;
        write_reg(REG_SPARE_HI, 6'h15);
        run_plane(6'd2, 1'b0, 0, 1'b0);
        run_plane(6'd7, 1'b1, 0, 1'b0);
        run_plane(6'($urandom_range(4, 8)), 1'($urandom), 2, 1'b0);
        run_plane(6'($urandom_range(4, 7)), 1'($urandom), 0, 1'b0);
    endtask

    // receiver stalls
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready = 1'b0;
        end
        else if (out_stall > 0) begin
            out_stall--;
            out_ready = 1'b0;
        end
        else begin
            out_stall = pick_gap();
            out_ready = (out_stall == 0);
        end
    end

    // result check against the oldest expectation
    always @(posedge clk) begin
        conv_out_t got;
        conv_out_t want;
        if (rst_n && out_valid && out_ready) begin
            got = '{value, out_row, out_col, saturated, last};
            outputs_seen++;
            if (saturated) sat_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output: value %h row %0d col %0d sat %b last %b",
                             value, out_row, out_col, saturated, last);
            end
            else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected value %h row %0d col %0d sat %b last %b",
                                 want.value, want.row, want.col, want.sat, want.last);
                        $display("          got value %h row %0d col %0d sat %b last %b",
                                 value, out_row, out_col, saturated, last);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (cfg_valid && cfg_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("depthwise_conv3x3_stream_top_test: FAIL");
            $finish;
        end
    end

    initial begin
        model_reset();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random_planes();
        drain();
        if (expected_q.size() != 0) mismatches++;
        $display("covered %0d items and %0d outputs (%0d saturated)",
                 items_sent, outputs_seen, sat_seen);
        $display("frame sizes 4 to 32 with clamping, both strides, ignored items, plane wrap");
        if (mismatches == 0)
            $display("depthwise_conv3x3_stream_top_test: PASS");
        else
            $display("depthwise_conv3x3_stream_top_test: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

/* depthwise_conv3x3_stream_top.f */
hw/rtl/dwc_pkg.sv
hw/rtl/dwc_front.sv
hw/rtl/dwc_queue.sv
hw/rtl/dwc_back.sv
hw/rtl/depthwise_conv3x3_stream_top.sv
verif/depthwise_conv3x3_stream_top_test.sv
